/* rtl/core/pcrc_pkg.sv */
`timescale 1ns / 1ps

package pcrc_pkg;

   // CRC-16-CCITT, MSB first, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_SECOND = 1'd1;

   localparam logic [7:0] HEADER_FIRST_RESET  = 8'd170;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'd85;

   // Position within the fixed part of the packet
   localparam logic [2:0] POS_HEADER_FIRST  = 3'd0;
   localparam logic [2:0] POS_HEADER_SECOND = 3'd1;
   localparam logic [2:0] POS_COMMAND       = 3'd2;
   localparam logic [2:0] POS_LENGTH        = 3'd3;
   localparam logic [2:0] POS_DATA          = 3'd4;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_END  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_CRC    = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] crc;
   } result_type;

endpackage

/* rtl/core/packet_header_length_crc_checker.sv */
`timescale 1ns / 1ps

// Checks framed packets presented one byte per item: two header bytes,
// command, length, then data, closed by an end item that carries the
// received CRC-16-CCITT. The processing stage is the byte-wide CRC
// update between the input register and the packet state; a new item is
// accepted in every cycle unless an end item waits, which it does only
// while the previous status is still held in the result register. The
// user must write header values through the csr port only while the
// block is idle; the block itself does not enforce it.
module packet_header_length_crc_checker #(
   parameter int unsigned MAX_PAYLOAD = 58
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [7:0]                           req_data_byte,
   input  logic [15:0]                          req_received_crc,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [15:0]                          rsp_computed_crc,
   input  logic                                 csr_wr_en,
   input  logic [pcrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pcrc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import pcrc_pkg::*;

   logic [7:0]  hdr_first_ff, hdr_second_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_mode_ff;
   logic [7:0]  s1_byte_ff;
   logic [15:0] s1_rx_ff;
   logic        s1_advance;
   logic        req_take;
   logic        rsp_load;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [15:0] rsp_crc_ff;
   result_type  result;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= HEADER_FIRST_RESET;
         hdr_second_ff <= HEADER_SECOND_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  hdr_first_ff  <= csr_data;
            CSR_HEADER_SECOND: hdr_second_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Byte items always advance; end items need room in the result register
   assign s1_advance = s1_valid_ff &&
                       (s1_mode_ff == MODE_BYTE || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;
   assign rsp_load   = s1_advance && s1_mode_ff == MODE_END;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_mode;
         s1_byte_ff <= req_data_byte;
         s1_rx_ff   <= req_received_crc;
      end
   end

   pcrc_frame #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_advance),
      .mode          (s1_mode_ff),
      .data_byte     (s1_byte_ff),
      .received_crc  (s1_rx_ff),
      .header_first  (hdr_first_ff),
      .header_second (hdr_second_ff),
      .result        (result)
   );

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= result.status;
         rsp_crc_ff    <= result.crc;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_computed_crc = rsp_crc_ff;

endmodule

/* rtl/core/pcrc_crc_byte.sv */
`timescale 1ns / 1ps

module pcrc_crc_byte (
   input  logic [15:0] crc,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);
   import pcrc_pkg::*;

   always_comb begin
      logic [15:0] c;
      c = crc ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      crc_next = c;
   end

endmodule

/* rtl/core/pcrc_frame.sv */
`timescale 1ns / 1ps

module pcrc_frame #(
   parameter int unsigned MAX_PAYLOAD = 58
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 mode,
   input  logic [7:0]           data_byte,
   input  logic [15:0]          received_crc,
   input  logic [7:0]           header_first,
   input  logic [7:0]           header_second,
   output pcrc_pkg::result_type result
);
   import pcrc_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic        fault_ff, fault_in;
   logic [15:0] crc_next;
   logic        short_pkt;

   pcrc_crc_byte u_crc (
      .crc       (crc_ff),
      .data_byte (data_byte),
      .crc_next  (crc_next)
   );

   always_comb begin
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      fault_in = fault_ff;
      if (step) begin
         if (mode == MODE_END) begin
            crc_in   = CRC_INIT;
            pos_in   = POS_HEADER_FIRST;
            len_in   = 8'd0;
            fault_in = 1'b0;
         end else if (pos_ff != POS_DATA) begin
            if (pos_ff == POS_HEADER_FIRST && data_byte != header_first) begin
               fault_in = 1'b1;
            end
            if (pos_ff == POS_HEADER_SECOND && data_byte != header_second) begin
               fault_in = 1'b1;
            end
            if (pos_ff == POS_LENGTH) begin
               len_in = data_byte;
               if (data_byte > MAX_LEN) begin
                  fault_in = 1'b1;
               end
            end
            crc_in = crc_next;
            pos_in = pos_ff + 3'd1;
         end else if (len_ff != 8'd0) begin
            crc_in = crc_next;
            len_in = len_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         pos_ff   <= POS_HEADER_FIRST;
         len_ff   <= 8'd0;
         fault_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         fault_ff <= fault_in;
      end
   end

   // Short: fixed part unfinished or declared data still owed
   assign short_pkt = (pos_ff != POS_DATA) || (len_ff != 8'd0);

   always_comb begin
      result.crc = crc_ff;
      priority if (fault_ff || short_pkt) begin
         result.status = STATUS_FORMAT;
      end else if (received_crc != crc_ff) begin
         result.status = STATUS_CRC;
      end else begin
         result.status = STATUS_OK;
      end
   end

endmodule

/* rtl/core/pcrc_checker.sv */
`timescale 1ns / 1ps

module pcrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_computed_crc
);
   import pcrc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_computed_crc))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_FORMAT ||
                    rsp_status == STATUS_CRC)
      else $error("undefined status code");

   // A fresh result must be caused by an accepted end item
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_mode == MODE_END, 2))
      else $error("result without end item");

endmodule

bind packet_header_length_crc_checker pcrc_checker u_pcrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_computed_crc (rsp_computed_crc)
);
